// ===== hw/rtl/halb_pkg.sv =====
// Shared types and codes for the health-aware load balancer.
// No dependencies; imported by the top level, the checker and the testbench.
package halb_pkg;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_SELECT  = 3'd2;
  localparam logic [2:0] OP_SUCCESS = 3'd3;
  localparam logic [2:0] OP_FAILURE = 3'd4;

  localparam logic [1:0] RC_DONE     = 2'd0;
  localparam logic [1:0] RC_NOTFOUND = 2'd1;
  localparam logic [1:0] RC_NONE     = 2'd2;
  localparam logic [1:0] RC_FULL     = 2'd3;

  localparam logic [1:0] HS_ACTIVE   = 2'd0;
  localparam logic [1:0] HS_DEGRADED = 2'd1;
  localparam logic [1:0] HS_FAILED   = 2'd2;

  localparam logic [31:0] U32_MAX   = 32'hFFFF_FFFF;
  localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [7:0]  RUN_MAX   = 8'hFF;
  // ceil(2^35 / 10): exact quotient for any 32-bit dividend after >> 35
  localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  weight;
    logic [31:0] pkt;
    logic [31:0] fail;
    logic [7:0]  run;
    logic [1:0]  health;
    logic        avail;
    logic [47:0] bytes;
    logic [31:0] sent;
    logic [23:0] lat;
  } entry_t;

endpackage

// ===== hw/rtl/health_aware_load_balancer.sv =====
// Health-aware load balancer top level: target table, sequencer, result register.
// Depends on halb_pkg, halb_mul and halb_rem.
//
// Usage: a request on the in_ channel carries an operation (add, remove,
// select, report success, report failure) and its operands. Every request
// yields exactly one result on the out_ channel. cfg_we/cfg_wdata set the
// weighted_mode bit (1 weighted draw, 0 round robin); the user must write it
// only while the block is idle, which the block itself does not enforce.
// The block works on one request at a time: in_stall is high from the cycle
// after acceptance until the result is loaded into the output register.
// Steps per request: add, remove and reports search the table by id; remove
// then compacts the table, and a success report updates the latency on the
// shared multiplier. Select takes the round-robin remainder from the
// bit-serial unit or scans the weights; a fallback best-rate scan on the
// shared multiplier forms two products per available target.
// A finished result sits in the output register while the next request is
// taken; if the receiver stalls, the following result waits in the sequencer
// and in_stall stays high. Reset empties the table, zeroes the weight sum and
// rotation counter, and clears out_valid.
module health_aware_load_balancer #(
  parameter int NUM_TARGETS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_target_id,
  input  logic [7:0]  in_weight,
  input  logic [15:0] in_random_fraction,
  input  logic [31:0] in_byte_count,
  input  logic [19:0] in_latency,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_code,
  output logic [15:0] out_chosen_target,
  output logic [1:0]  out_target_status,
  output logic [3:0]  out_available_targets,
  output logic [10:0] out_weight_total,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import halb_pkg::*;

  localparam int CW  = $clog2(NUM_TARGETS + 1);
  localparam int IW  = $clog2(NUM_TARGETS);
  localparam int WSW = $clog2(255 * NUM_TARGETS + 1);
  localparam logic [CW-1:0] FULL = CW'(NUM_TARGETS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIND  = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_SUCC1 = 4'd3;
  localparam logic [3:0] S_SUCC2 = 4'd4;
  localparam logic [3:0] S_FAIL  = 4'd5;
  localparam logic [3:0] S_RR    = 4'd6;
  localparam logic [3:0] S_WMUL  = 4'd7;
  localparam logic [3:0] S_WSCAN = 4'd8;
  localparam logic [3:0] S_PICK  = 4'd9;
  localparam logic [3:0] S_BEST1 = 4'd10;
  localparam logic [3:0] S_BEST2 = 4'd11;
  localparam logic [3:0] S_BEST3 = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  entry_t tbl_r [NUM_TARGETS];

  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt, pos_r, pos_nxt, pick_r, pick_nxt, best_r, best_nxt;
  logic           best_found_r, best_found_nxt;
  logic [31:0]    bn_r, bn_nxt, bd_r, bd_nxt;
  logic [63:0]    p1_r, p1_nxt;
  logic [WSW-1:0] cum_r, cum_nxt;
  logic [2:0]     op_r, op_nxt;
  logic [15:0]    id_r, id_nxt;
  logic [7:0]     w_r, w_nxt;
  logic [15:0]    frac_r, frac_nxt;
  logic [31:0]    bytes_r, bytes_nxt;
  logic [19:0]    lat_r, lat_nxt;
  logic [CW-1:0]  count_r, count_nxt, avail_r, avail_nxt;
  logic [WSW-1:0] wsum_r, wsum_nxt;
  logic [31:0]    rot_r, rot_nxt;
  logic           mode_r;
  logic [1:0]     res_code_r, res_code_nxt, res_status_r, res_status_nxt;
  logic [15:0]    res_chosen_r, res_chosen_nxt;
  logic           out_valid_r;
  logic [1:0]     out_code_r, out_status_r;
  logic [15:0]    out_chosen_r;
  logic [3:0]     out_avail_r;
  logic [10:0]    out_wsum_r;

  logic [CW-1:0]  rd_sel;
  entry_t         rd, wr_data;
  logic           wr_en;
  logic [CW-1:0]  wr_sel;
  logic           mul_go;
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    prod;
  logic           rem_start, rem_done;
  logic [CW-1:0]  rem_val;
  logic [31:0]    n_k, d_k;
  logic [31:0]    p_inc, f_inc, n_s, n_f;
  logic [7:0]     run_inc;
  logic [48:0]    byte_sum;
  logic [34:0]    n5_s, n5_f;
  logic           load_out;

  halb_mul u_mul (
    .clk  (clk),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  halb_rem #(.CW(CW)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rot_r),
    .divisor  (count_r),
    .rem      (rem_val),
    .done     (rem_done)
  );

  // single table read port
  always_comb begin
    case (state_r)
      S_SHIFT:         rd_sel = idx_r + CW'(1);
      S_SUCC1, S_SUCC2,
      S_FAIL:          rd_sel = pos_r;
      S_PICK:          rd_sel = pick_r;
      S_FIN:           rd_sel = best_r;
      default:         rd_sel = idx_r;
    endcase
  end
  assign rd = tbl_r[rd_sel[IW-1:0]];

  // success rate of the entry on the read port; no packets counts as 1
  always_comb begin
    if (rd.pkt == 32'd0) begin
      n_k = 32'd1;
      d_k = 32'd1;
    end else begin
      n_k = (rd.pkt >= rd.fail) ? rd.pkt - rd.fail : 32'd0;
      d_k = rd.pkt;
    end
  end

  // report updates
  assign p_inc    = (rd.pkt == U32_MAX) ? rd.pkt : rd.pkt + 32'd1;
  assign f_inc    = (rd.fail == U32_MAX) ? rd.fail : rd.fail + 32'd1;
  assign run_inc  = (rd.run == RUN_MAX) ? rd.run : rd.run + 8'd1;
  assign n_s      = (p_inc >= rd.fail) ? p_inc - rd.fail : 32'd0;
  assign n_f      = (p_inc >= f_inc) ? p_inc - f_inc : 32'd0;
  assign n5_s     = {3'b0, n_s} + {1'b0, n_s, 2'b0};
  assign n5_f     = {3'b0, n_f} + {1'b0, n_f, 2'b0};
  assign byte_sum = {1'b0, rd.bytes} + {17'b0, bytes_r};

  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    pick_nxt       = pick_r;
    best_nxt       = best_r;
    best_found_nxt = best_found_r;
    bn_nxt         = bn_r;
    bd_nxt         = bd_r;
    p1_nxt         = p1_r;
    cum_nxt        = cum_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    w_nxt          = w_r;
    frac_nxt       = frac_r;
    bytes_nxt      = bytes_r;
    lat_nxt        = lat_r;
    count_nxt      = count_r;
    avail_nxt      = avail_r;
    wsum_nxt       = wsum_r;
    rot_nxt        = rot_r;
    res_code_nxt   = res_code_r;
    res_status_nxt = res_status_r;
    res_chosen_nxt = res_chosen_r;
    wr_en          = 1'b0;
    wr_sel         = idx_r;
    wr_data        = rd;
    mul_go         = 1'b0;
    mul_a          = bn_r;
    mul_b          = d_k;
    rem_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_operation;
          id_nxt         = in_target_id;
          w_nxt          = in_weight;
          frac_nxt       = in_random_fraction;
          bytes_nxt      = in_byte_count;
          lat_nxt        = in_latency;
          idx_nxt        = '0;
          res_code_nxt   = RC_NOTFOUND;
          res_status_nxt = HS_ACTIVE;
          res_chosen_nxt = in_target_id;
          if (in_operation == OP_SELECT) begin
            res_chosen_nxt = 16'd0;
            if (count_r == '0) begin
              res_code_nxt = RC_NONE;
              state_nxt    = S_DONE;
            end else if (mode_r) begin
              if (wsum_r == '0) begin
                pick_nxt  = '0;
                state_nxt = S_PICK;
              end else begin
                state_nxt = S_WMUL;
              end
            end else begin
              rem_start = 1'b1;
              state_nxt = S_RR;
            end
          end else if (in_operation inside {OP_ADD, OP_REMOVE, OP_SUCCESS, OP_FAILURE}) begin
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_FIND: begin
        if (idx_r == count_r) begin
          if (op_r == OP_ADD) begin
            if (count_r == FULL) begin
              res_code_nxt = RC_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_sel         = count_r;
              wr_data        = '0;
              wr_data.id     = id_r;
              wr_data.weight = w_r;
              wr_data.health = HS_ACTIVE;
              wr_data.avail  = 1'b1;
              count_nxt      = count_r + CW'(1);
              avail_nxt      = avail_r + CW'(1);
              wsum_nxt       = wsum_r + WSW'(w_r);
              res_code_nxt   = RC_DONE;
            end
          end
          state_nxt = S_DONE;
        end else if (rd.id == id_r) begin
          pos_nxt = idx_r;
          case (op_r)
            OP_REMOVE: begin
              wsum_nxt  = wsum_r - WSW'(rd.weight);
              avail_nxt = avail_r - CW'(rd.avail);
              state_nxt = S_SHIFT;
            end
            OP_SUCCESS: state_nxt = S_SUCC1;
            OP_FAILURE: state_nxt = S_FAIL;
            default:    state_nxt = S_DONE;
          endcase
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      // move later entries down one place
      S_SHIFT: begin
        if (idx_r + CW'(1) < count_r) begin
          wr_en   = 1'b1;
          wr_sel  = idx_r;
          wr_data = rd;
          idx_nxt = idx_r + CW'(1);
        end else begin
          count_nxt    = count_r - CW'(1);
          res_code_nxt = RC_DONE;
          state_nxt    = S_DONE;
        end
      end

      S_SUCC1: begin
        mul_go    = 1'b1;
        mul_a     = ({8'b0, rd.lat} << 3) + {8'b0, rd.lat} + {12'b0, lat_r} + 32'd5;
        mul_b     = RECIP_10;
        state_nxt = S_SUCC2;
      end

      S_SUCC2: begin
        wr_en         = 1'b1;
        wr_sel        = pos_r;
        wr_data       = rd;
        wr_data.pkt   = p_inc;
        wr_data.run   = 8'd0;
        wr_data.bytes = byte_sum[48] ? BYTES_MAX : byte_sum[47:0];
        wr_data.sent  = (rd.sent == U32_MAX) ? rd.sent : rd.sent + 32'd1;
        wr_data.lat   = prod[58:35];
        if (n5_s > {1'b0, p_inc, 2'b0}) begin
          wr_data.health = HS_ACTIVE;
          wr_data.avail  = 1'b1;
          avail_nxt      = avail_r + CW'(!rd.avail);
        end
        res_status_nxt = wr_data.health;
        res_code_nxt   = RC_DONE;
        state_nxt      = S_DONE;
      end

      S_FAIL: begin
        wr_en        = 1'b1;
        wr_sel       = pos_r;
        wr_data      = rd;
        wr_data.pkt  = p_inc;
        wr_data.fail = f_inc;
        wr_data.run  = run_inc;
        if (run_inc >= 8'd3 || n5_f < {3'b0, p_inc}) begin
          wr_data.health = HS_FAILED;
          wr_data.avail  = 1'b0;
          avail_nxt      = avail_r - CW'(rd.avail);
        end else if ({n_f, 1'b0} < {1'b0, p_inc}) begin
          wr_data.health = HS_DEGRADED;
        end
        res_status_nxt = wr_data.health;
        res_code_nxt   = RC_DONE;
        state_nxt      = S_DONE;
      end

      S_RR: begin
        if (rem_done) begin
          pick_nxt  = rem_val;
          rot_nxt   = rot_r + 32'd1;
          state_nxt = S_PICK;
        end
      end

      S_WMUL: begin
        mul_go    = 1'b1;
        mul_a     = {16'b0, frac_r};
        mul_b     = 32'(wsum_r);
        idx_nxt   = '0;
        cum_nxt   = '0;
        state_nxt = S_WSCAN;
      end

      // running sum of available weights against the draw
      S_WSCAN: begin
        if (idx_r == count_r) begin
          pick_nxt  = '0;
          state_nxt = S_PICK;
        end else begin
          if (rd.avail) begin
            cum_nxt = cum_r + WSW'(rd.weight);
            if (prod <= 64'({cum_nxt, 16'b0})) begin
              pick_nxt  = idx_r;
              state_nxt = S_PICK;
            end
          end
          idx_nxt = idx_r + CW'(1);
        end
      end

      S_PICK: begin
        if (pick_r < count_r && rd.avail) begin
          res_code_nxt   = RC_DONE;
          res_chosen_nxt = rd.id;
          res_status_nxt = rd.health;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          bn_nxt         = 32'd0;
          bd_nxt         = 32'd1;
          state_nxt      = S_BEST1;
        end
      end

      // fallback: cross-multiplied rate compare, two products per available entry
      S_BEST1: begin
        if (idx_r == count_r) begin
          state_nxt = S_FIN;
        end else if (!rd.avail) begin
          idx_nxt = idx_r + CW'(1);
        end else begin
          mul_go    = 1'b1;
          mul_a     = bn_r;
          mul_b     = d_k;
          state_nxt = S_BEST2;
        end
      end

      S_BEST2: begin
        p1_nxt    = prod;
        mul_go    = 1'b1;
        mul_a     = n_k;
        mul_b     = bd_r;
        state_nxt = S_BEST3;
      end

      S_BEST3: begin
        if (!best_found_r || p1_r < prod) begin
          best_found_nxt = 1'b1;
          best_nxt       = idx_r;
          bn_nxt         = n_k;
          bd_nxt         = d_k;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_BEST1;
      end

      S_FIN: begin
        if (best_found_r) begin
          res_code_nxt   = RC_DONE;
          res_chosen_nxt = rd.id;
          res_status_nxt = rd.health;
        end else begin
          res_code_nxt = RC_NONE;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_r[wr_sel[IW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      avail_r     <= '0;
      wsum_r      <= '0;
      rot_r       <= 32'd0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      avail_r <= avail_nxt;
      wsum_r  <= wsum_nxt;
      rot_r   <= rot_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    pick_r       <= pick_nxt;
    best_r       <= best_nxt;
    best_found_r <= best_found_nxt;
    bn_r         <= bn_nxt;
    bd_r         <= bd_nxt;
    p1_r         <= p1_nxt;
    cum_r        <= cum_nxt;
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    w_r          <= w_nxt;
    frac_r       <= frac_nxt;
    bytes_r      <= bytes_nxt;
    lat_r        <= lat_nxt;
    res_code_r   <= res_code_nxt;
    res_status_r <= res_status_nxt;
    res_chosen_r <= res_chosen_nxt;
    if (load_out) begin
      out_code_r   <= res_code_r;
      out_chosen_r <= res_chosen_r;
      out_status_r <= res_status_r;
      out_avail_r  <= 4'(avail_r);
      out_wsum_r   <= 11'(wsum_r);
    end
  end

  assign in_stall              = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_result_code       = out_code_r;
  assign out_chosen_target     = out_chosen_r;
  assign out_target_status     = out_status_r;
  assign out_available_targets = out_avail_r;
  assign out_weight_total      = out_wsum_r;
endmodule

// ===== hw/rtl/halb_mul.sv =====
// Shared 32x32 multiplier with registered product.
// Depends on nothing; used by the load balancer sequencer.
module halb_mul (
  input  logic        clk,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);
  logic [63:0] prod_r;

  // hold the product until the next issue
  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= {32'b0, a} * {32'b0, b};
    end
  end

  assign prod = prod_r;
endmodule

// ===== hw/rtl/halb_rem.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo a small divisor.
// Depends on nothing; one quotient bit per cycle.
module halb_rem #(
  parameter int CW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [CW-1:0] divisor,
  output logic [CW-1:0] rem,
  output logic          done
);
  logic [CW-1:0] rem_r, rem_nxt;
  logic [31:0]   dvd_r, dvd_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[31]};
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      cnt_nxt  = 5'd31;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[CW-1:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rem  = rem_r;
  assign done = done_r;
endmodule

// ===== hw/rtl/halb_checker.sv =====
// Port-level checks for the health-aware load balancer, bound to the top level.
// Depends on halb_pkg.
module halb_checker #(
  parameter int NUM_TARGETS = 8
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_result_code,
  input logic [15:0] out_chosen_target,
  input logic [1:0]  out_target_status,
  input logic [3:0]  out_available_targets
);
  import halb_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_chosen_target)
      && $stable(out_result_code))
    else $error("stalled result changed");

  // only select answers none-available, and then with no target
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_code == RC_NONE |-> out_chosen_target == 16'd0
      && out_target_status == HS_ACTIVE)
    else $error("none-available result carries a target");

  // no result ever carries health status code three
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_target_status != 2'd3)
    else $error("illegal health status");

  a_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_available_targets) <= NUM_TARGETS)
    else $error("available count exceeds table size");
endmodule

bind health_aware_load_balancer halb_checker #(.NUM_TARGETS(NUM_TARGETS)) u_halb_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_result_code       (out_result_code),
  .out_chosen_target     (out_chosen_target),
  .out_target_status     (out_target_status),
  .out_available_targets (out_available_targets)
);

// ===== dv/tb.sv =====
// Self-checking testbench for health_aware_load_balancer: random and directed requests,
// results predicted from a behavioural copy of the target table and checked in order.
// Depends on halb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import halb_pkg::*;

  localparam int SLOTS = 8;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] id;
    logic [7:0]  weight;
    logic [15:0] frac;
    logic [31:0] bytes;
    logic [19:0] lat;
  } request_t;

  typedef struct {
    logic [1:0]  code;
    logic [15:0] chosen;
    logic [1:0]  status;
    logic [3:0]  avail;
    logic [10:0] wtotal;
  } answer_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_operation = '0;
  logic [15:0] in_target_id = '0;
  logic [7:0] in_weight = '0;
  logic [15:0] in_random_fraction = '0;
  logic [31:0] in_byte_count = '0;
  logic [19:0] in_latency = '0;
  logic out_valid;
  logic out_stall = 1;
  logic [1:0] out_result_code;
  logic [15:0] out_chosen_target;
  logic [1:0] out_target_status;
  logic [3:0] out_available_targets;
  logic [10:0] out_weight_total;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  health_aware_load_balancer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_target_id(in_target_id), .in_weight(in_weight),
    .in_random_fraction(in_random_fraction), .in_byte_count(in_byte_count),
    .in_latency(in_latency),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_code(out_result_code), .out_chosen_target(out_chosen_target),
    .out_target_status(out_target_status), .out_available_targets(out_available_targets),
    .out_weight_total(out_weight_total),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int mismatches = 0;
  int answers_seen = 0;
  bit quiet = 0;

  // Behavioural copy of the target table
  logic [15:0] t_id[SLOTS];
  logic [7:0]  t_wt[SLOTS];
  logic [31:0] t_pkt[SLOTS];
  logic [31:0] t_fail[SLOTS];
  logic [7:0]  t_run[SLOTS];
  logic [1:0]  t_health[SLOTS];
  logic        t_up[SLOTS];
  logic [47:0] t_bytes[SLOTS];
  logic [31:0] t_sent[SLOTS];
  logic [23:0] t_lat[SLOTS];
  int          t_count = 0;
  logic [10:0] t_wsum = '0;
  logic [31:0] t_rot = '0;
  logic        t_weighted = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Append a request to the tail of the pending queue
  function automatic void queue_request(request_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic int find_target(logic [15:0] id);
    for (int k = 0; k < t_count; k++) if (t_id[k] == id) return k;
    return -1;
  endfunction

  function automatic void success_ratio(int k, output longint unsigned n,
                                        output longint unsigned d);
    if (t_pkt[k] == 0) begin
      n = 1;
      d = 1;
    end else begin
      n = (t_pkt[k] >= t_fail[k]) ? t_pkt[k] - t_fail[k] : 0;
      d = t_pkt[k];
    end
  endfunction

  function automatic int healthiest_target();
    int best;
    longint unsigned bn, bd, n, d;
    best = -1;
    bn = 0;
    bd = 1;
    for (int k = 0; k < t_count; k++) begin
      if (!t_up[k]) continue;
      success_ratio(k, n, d);
      if (best < 0 || bn * d < n * bd) begin
        best = k;
        bn = n;
        bd = d;
      end
    end
    return best;
  endfunction

  function automatic int weighted_draw(logic [15:0] frac);
    longint unsigned draw, cum;
    cum = 0;
    if (t_wsum == 0) return 0;
    draw = longint'(frac) * t_wsum;
    for (int k = 0; k < t_count; k++) begin
      if (!t_up[k]) continue;
      cum += t_wt[k];
      if (draw <= (cum << 16)) return k;
    end
    return 0;
  endfunction

  function automatic answer_t balance_request(request_t r);
    answer_t a;
    int pos, k;
    longint unsigned n, d, sum;
    a.code = RC_NOTFOUND;
    a.chosen = r.id;
    a.status = HS_ACTIVE;
    case (r.op)
      OP_ADD: begin
        if (find_target(r.id) >= 0) a.code = RC_NOTFOUND;
        else if (t_count >= SLOTS) a.code = RC_FULL;
        else begin
          k = t_count;
          t_id[k] = r.id;
          t_wt[k] = r.weight;
          t_pkt[k] = 0;
          t_fail[k] = 0;
          t_run[k] = 0;
          t_health[k] = HS_ACTIVE;
          t_up[k] = 1;
          t_bytes[k] = 0;
          t_sent[k] = 0;
          t_lat[k] = 0;
          t_count++;
          t_wsum += r.weight;
          a.code = RC_DONE;
        end
      end
      OP_REMOVE: begin
        pos = find_target(r.id);
        if (pos >= 0) begin
          t_wsum -= t_wt[pos];
          for (k = pos; k + 1 < t_count; k++) begin
            t_id[k] = t_id[k+1];
            t_wt[k] = t_wt[k+1];
            t_pkt[k] = t_pkt[k+1];
            t_fail[k] = t_fail[k+1];
            t_run[k] = t_run[k+1];
            t_health[k] = t_health[k+1];
            t_up[k] = t_up[k+1];
            t_bytes[k] = t_bytes[k+1];
            t_sent[k] = t_sent[k+1];
            t_lat[k] = t_lat[k+1];
          end
          t_count--;
          a.code = RC_DONE;
        end
      end
      OP_SELECT: begin
        a.chosen = '0;
        if (t_count == 0) a.code = RC_NONE;
        else begin
          if (t_weighted) k = weighted_draw(r.frac);
          else begin
            k = t_rot % t_count;
            t_rot++;
          end
          pos = (k < t_count && t_up[k]) ? k : healthiest_target();
          if (pos < 0) a.code = RC_NONE;
          else begin
            a.code = RC_DONE;
            a.chosen = t_id[pos];
            a.status = t_health[pos];
          end
        end
      end
      OP_SUCCESS: begin
        pos = find_target(r.id);
        if (pos >= 0) begin
          if (t_pkt[pos] != U32_MAX) t_pkt[pos]++;
          t_run[pos] = 0;
          sum = longint'(t_bytes[pos]) + r.bytes;
          t_bytes[pos] = (sum > BYTES_MAX) ? BYTES_MAX : sum[47:0];
          if (t_sent[pos] != U32_MAX) t_sent[pos]++;
          t_lat[pos] = 24'((longint'(t_lat[pos]) * 9 + r.lat + 5) / 10);
          success_ratio(pos, n, d);
          if (n * 5 > d * 4) begin
            t_health[pos] = HS_ACTIVE;
            t_up[pos] = 1;
          end
          a.status = t_health[pos];
          a.code = RC_DONE;
        end
      end
      OP_FAILURE: begin
        pos = find_target(r.id);
        if (pos >= 0) begin
          if (t_pkt[pos] != U32_MAX) t_pkt[pos]++;
          if (t_fail[pos] != U32_MAX) t_fail[pos]++;
          if (t_run[pos] != RUN_MAX) t_run[pos]++;
          success_ratio(pos, n, d);
          if (t_run[pos] >= 3 || n * 5 < d) begin
            t_health[pos] = HS_FAILED;
            t_up[pos] = 0;
          end else if (n * 2 < d) t_health[pos] = HS_DEGRADED;
          a.status = t_health[pos];
          a.code = RC_DONE;
        end
      end
      default: ;
    endcase
    a.avail = '0;
    for (k = 0; k < t_count; k++) if (t_up[k]) a.avail++;
    a.wtotal = t_wsum;
    return a;
  endfunction

  // Mostly short gaps, a few long ones; none at all in a quiet phase
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic request_t make_request(logic [2:0] op, logic [15:0] id,
                                            logic [7:0] weight = 8'd1,
                                            logic [15:0] frac = '0,
                                            logic [31:0] bytes = '0,
                                            logic [19:0] lat = '0);
    request_t r;
    r.op = op;
    r.id = id;
    r.weight = weight;
    r.frac = frac;
    r.bytes = bytes;
    r.lat = lat;
    return r;
  endfunction

  function automatic request_t random_request();
    logic [15:0] id_pool[12] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003,
                                 16'h00A5, 16'h5A5A, 16'h8000, 16'h1234, 16'h7FFF,
                                 16'hC3C3, 16'h0100};
    request_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 16) r.op = OP_ADD;
    else if (roll < 26) r.op = OP_REMOVE;
    else if (roll < 52) r.op = OP_SELECT;
    else if (roll < 74) r.op = OP_SUCCESS;
    else if (roll < 96) r.op = OP_FAILURE;
    else r.op = 3'(OP_FAILURE + $urandom_range(1, 3));
    r.id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 11)];
    r.weight = 8'($urandom);
    r.frac = 16'($urandom);
    r.bytes = $urandom;
    r.lat = 20'($urandom);
    return r;
  endfunction

  // Sender: holds a stalled request, otherwise moves on to the next one after a gap
  always @(posedge clk) begin
    int gap;
    request_t cur;
    if (!rst_n) begin
      in_valid <= 0;
      gap = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_answers.insert(expected_answers.size(), balance_request(cur));
      if (!(in_valid && in_stall)) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 0;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          in_operation <= cur.op;
          in_target_id <= cur.id;
          in_weight <= cur.weight;
          in_random_fraction <= cur.frac;
          in_byte_count <= cur.bytes;
          in_latency <= cur.lat;
          in_valid <= 1;
          gap = idle_gap();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    int stall_left;
    int hold_left;
    bit held;
    answer_t e;
    if (!rst_n) begin
      out_stall <= 1;
      stall_left = 0;
      hold_left = 0;
      held = 0;
    end else begin
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (expected_answers.size() == 0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("tb: result with nothing expected: code %0d id %h",
                     out_result_code, out_chosen_target);
        end else begin
          e = expected_answers.pop_front();
          if (e.code !== out_result_code || e.chosen !== out_chosen_target ||
              e.status !== out_target_status || e.avail !== out_available_targets ||
              e.wtotal !== out_weight_total) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("tb: mismatch exp code %0d id %h st %0d av %0d wt %0d / got %0d %h %0d %0d %0d",
                       e.code, e.chosen, e.status, e.avail, e.wtotal,
                       out_result_code, out_chosen_target, out_target_status,
                       out_available_targets, out_weight_total);
          end
        end
      end
      if (!held && answers_seen >= 300) begin
        held = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1;
      end else begin
        stall_left = idle_gap();
        out_stall <= (stall_left > 0);
      end
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Sample at the falling edge so queue and valid updates of the rising edge have settled
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_answers.size() > 0)
      @(negedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_mode(logic mode);
    cfg_we <= 1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 0;
    t_weighted = mode;
    @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_mode(0);
    queue_request(make_request(OP_SELECT, 16'h0000));
    queue_request(make_request(OP_ADD, 16'h0000, 8'd255));
    queue_request(make_request(OP_ADD, 16'hFFFF, 8'd0));
    queue_request(make_request(OP_ADD, 16'h0000, 8'd7));
    queue_request(make_request(OP_REMOVE, 16'h1234));
    for (int k = 1; k <= 6; k++)
      queue_request(make_request(OP_ADD, 16'(k), 8'(k * 40)));
    queue_request(make_request(OP_ADD, 16'h0007, 8'd9));
    queue_request(make_request(OP_SUCCESS, 16'hFFFF, 8'd0, 16'd0,
                               32'hFFFF_FFFF, 20'hFFFFF));
    repeat (3) queue_request(make_request(OP_FAILURE, 16'h0001));
    repeat (3) queue_request(make_request(OP_SELECT, 16'h0000));
    queue_request(make_request(OP_REMOVE, 16'h0003));
    for (int k = 1; k <= 3; k++)
      queue_request(make_request(3'(OP_FAILURE + k), 16'h00A5));
    queue_request(make_request(OP_SUCCESS, 16'h0009));
    drain();

    // weighted draw at the ends of the fraction range, with and without fallback
    set_mode(1);
    queue_request(make_request(OP_SELECT, 16'h0000, 8'd0, 16'h0000));
    queue_request(make_request(OP_SELECT, 16'h0000, 8'd0, 16'hFFFF));
    repeat (3) queue_request(make_request(OP_FAILURE, 16'h0002));
    queue_request(make_request(OP_SELECT, 16'h0000, 8'd0, 16'h3000));
    queue_request(make_request(OP_SUCCESS, 16'h0001));
    queue_request(make_request(OP_REMOVE, 16'h0000));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      set_mode(phase[0] ^ 1'b1);
      quiet = (phase == 3);
      for (int k = 0; k < 270; k++) queue_request(random_request());
      drain();
    end

    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
